// File: hdl/rmt_pkg.sv
// Shared types and constants for the masked rule-table state machine.
// No dependencies; imported by the top level.
package rmt_pkg;

    localparam int FIELD_W = 8;
    localparam int INDEX_W = 6;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    localparam int RESET_STATE = 10;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } rmt_state_t;

endpackage

// File: hdl/rmt_rule_mem.sv
// Rule table storage: one-write, one-read memory with registered read data,
// plus a flip-flop valid bit per row cleared by reset. No dependencies.
module rmt_rule_mem #(
    parameter int ROWS   = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic              wr_valid,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic              rd_valid,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:ROWS-1];
    logic [ROWS-1:0]   row_valid_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= wr_valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

// File: hdl/rmt_row_cmp.sv
// Shared row compare unit: checks one rule row against the current state
// and the event's key and flag bits. No dependencies.
module rmt_row_cmp #(
    parameter int STATE_WIDTH = 8,
    parameter int KEY_WIDTH   = 8,
    parameter int FLAG_WIDTH  = 8
) (
    input  logic                   row_valid,
    input  logic [STATE_WIDTH-1:0] row_state,
    input  logic [KEY_WIDTH-1:0]   row_key_mask,
    input  logic [KEY_WIDTH-1:0]   row_key_pattern,
    input  logic [FLAG_WIDTH-1:0]  row_flag_mask,
    input  logic [FLAG_WIDTH-1:0]  row_flag_pattern,
    input  logic [STATE_WIDTH-1:0] cur_state,
    input  logic [KEY_WIDTH-1:0]   key_bits,
    input  logic [FLAG_WIDTH-1:0]  flag_bits,
    output logic                   hit
);

    logic key_ok;
    logic flag_ok;

    assign key_ok  = ((key_bits ^ row_key_pattern) & row_key_mask) == '0;
    assign flag_ok = ((flag_bits ^ row_flag_pattern) & row_flag_mask) == '0;
    assign hit     = row_valid && (row_state == cur_state) && key_ok && flag_ok;

endmodule

// File: hdl/masked_rule_table_state_machine.sv
// Top level of the masked rule-table state machine: sequencer, state registers
// and result register. Uses rmt_pkg, rmt_rule_mem and rmt_row_cmp.
//
// A load item (mode 0) writes one rule row and gives no result. An event
// item (mode 1) scans the table one row per cycle through the shared
// compare unit, reading rows from a registered-output memory, and stops at
// the lowest-indexed matching row. item_stall is high while the scan runs
// and while a finished result is held back by result_stall with the result
// register already full. Rows reset to invalid through per-row valid
// flip-flops, so no clearing pass is needed after reset.
module masked_rule_table_state_machine #(
    parameter int ROWS        = 64,
    parameter int STATE_WIDTH = 8,
    parameter int KEY_WIDTH   = 8,
    parameter int FLAG_WIDTH  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         mode,
    input  logic [rmt_pkg::INDEX_W-1:0]  row_index,
    input  logic                         row_valid,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_state,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_key_mask,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_key_pattern,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_flag_mask,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_flag_pattern,
    input  logic [rmt_pkg::FIELD_W-1:0]  row_next_state,
    input  logic [rmt_pkg::FIELD_W-1:0]  key_bits,
    input  logic [rmt_pkg::FIELD_W-1:0]  flag_bits,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         matched,
    output logic [rmt_pkg::INDEX_W-1:0]  match_row,
    output logic [rmt_pkg::FIELD_W-1:0]  new_state,
    output logic [rmt_pkg::FIELD_W-1:0]  prior_state
);

    import rmt_pkg::*;

    localparam int IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DATA_W = 2 * STATE_WIDTH + 2 * KEY_WIDTH + 2 * FLAG_WIDTH;
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ROWS - 1);

    rmt_state_t state_reg, state_next;

    logic [STATE_WIDTH-1:0] cur_reg, cur_next;
    logic [STATE_WIDTH-1:0] prev_reg, prev_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [FLAG_WIDTH-1:0]  flag_reg, flag_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic                   issuing_reg, issuing_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]       res_row_reg, res_row_next;
    logic [STATE_WIDTH-1:0] res_dst_reg, res_dst_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_matched_reg, out_matched_next;
    logic [INDEX_W-1:0]     out_row_reg, out_row_next;
    logic [FIELD_W-1:0]     out_new_reg, out_new_next;
    logic [FIELD_W-1:0]     out_prior_reg, out_prior_next;

    logic                   accept;
    logic                   load_acc;
    logic                   evt_acc;
    logic                   row_fits;
    logic                   issue_en;
    logic                   out_free;
    logic                   out_load;
    logic                   hit;
    logic                   decide;

    logic [DATA_W-1:0]      wr_data;
    logic                   rd_valid;
    logic [DATA_W-1:0]      rd_data;
    logic [STATE_WIDTH-1:0] rd_src;
    logic [KEY_WIDTH-1:0]   rd_kmask;
    logic [KEY_WIDTH-1:0]   rd_kpat;
    logic [FLAG_WIDTH-1:0]  rd_fmask;
    logic [FLAG_WIDTH-1:0]  rd_fpat;
    logic [STATE_WIDTH-1:0] rd_dst;

    assign accept   = item_valid && !item_stall;
    assign load_acc = accept && (mode == MODE_LOAD);
    assign evt_acc  = accept && (mode == MODE_EVENT);
    assign row_fits = int'(row_index) < ROWS;
    assign out_free = !out_valid_reg || !result_stall;

    assign wr_data = {STATE_WIDTH'(row_state),
                      KEY_WIDTH'(row_key_mask),
                      KEY_WIDTH'(row_key_pattern),
                      FLAG_WIDTH'(row_flag_mask),
                      FLAG_WIDTH'(row_flag_pattern),
                      STATE_WIDTH'(row_next_state)};

    assign {rd_src, rd_kmask, rd_kpat, rd_fmask, rd_fpat, rd_dst} = rd_data;

    rmt_rule_mem #(
        .ROWS   (ROWS),
        .IDX_W  (IDX_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_acc && row_fits),
        .wr_addr  (IDX_W'(row_index)),
        .wr_valid (row_valid),
        .wr_data  (wr_data),
        .rd_en    (issue_en),
        .rd_addr  (addr_reg),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    rmt_row_cmp #(
        .STATE_WIDTH (STATE_WIDTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .FLAG_WIDTH  (FLAG_WIDTH)
    ) u_cmp (
        .row_valid        (rd_valid),
        .row_state        (rd_src),
        .row_key_mask     (rd_kmask),
        .row_key_pattern  (rd_kpat),
        .row_flag_mask    (rd_fmask),
        .row_flag_pattern (rd_fpat),
        .cur_state        (cur_reg),
        .key_bits         (key_reg),
        .flag_bits        (flag_reg),
        .hit              (hit)
    );

    assign decide = (state_reg == ST_SCAN) && pend_reg && (hit || (pend_idx_reg == LAST_ROW));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (decide)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        item_stall = 1'b1;
        issue_en   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_SCAN:
            begin
                issue_en = issuing_reg;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        key_next         = key_reg;
        flag_next        = flag_reg;
        addr_next        = addr_reg;
        issuing_next     = issuing_reg;
        pend_next        = issue_en;
        pend_idx_next    = addr_reg;
        res_hit_next     = res_hit_reg;
        res_row_next     = res_row_reg;
        res_dst_next     = res_dst_reg;
        out_valid_next   = out_valid_reg && result_stall;
        out_matched_next = out_matched_reg;
        out_row_next     = out_row_reg;
        out_new_next     = out_new_reg;
        out_prior_next   = out_prior_reg;

        if (evt_acc)
        begin
            key_next     = KEY_WIDTH'(key_bits);
            flag_next    = FLAG_WIDTH'(flag_bits);
            addr_next    = '0;
            issuing_next = 1'b1;
            pend_next    = 1'b0;
        end

        if (issue_en)
        begin
            if (addr_reg == LAST_ROW)
            begin
                issuing_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        if (decide)
        begin
            issuing_next = 1'b0;
            res_hit_next = hit;
            res_row_next = hit ? pend_idx_reg : '0;
            res_dst_next = rd_dst;
        end

        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_matched_next = res_hit_reg;
            out_row_next     = INDEX_W'(res_row_reg);
            if (res_hit_reg)
            begin
                cur_next       = res_dst_reg;
                prev_next      = cur_reg;
                out_new_next   = FIELD_W'(res_dst_reg);
                out_prior_next = FIELD_W'(cur_reg);
            end
            else
            begin
                out_new_next   = FIELD_W'(cur_reg);
                out_prior_next = FIELD_W'(prev_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= STATE_WIDTH'(RESET_STATE);
            prev_reg      <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        flag_reg        <= flag_next;
        addr_reg        <= addr_next;
        pend_idx_reg    <= pend_idx_next;
        res_hit_reg     <= res_hit_next;
        res_row_reg     <= res_row_next;
        res_dst_reg     <= res_dst_next;
        out_matched_reg <= out_matched_next;
        out_row_reg     <= out_row_next;
        out_new_reg     <= out_new_next;
        out_prior_reg   <= out_prior_next;
    end

    assign result_valid = out_valid_reg;
    assign matched      = out_matched_reg;
    assign match_row    = out_row_reg;
    assign new_state    = out_new_reg;
    assign prior_state  = out_prior_reg;

endmodule
